// ----- rtl/pfsmd_pkg.sv -----
// Shared types, constants and the error-share helper function of the mono dither block.
`timescale 1ns / 1ps

package pfsmd_pkg;

    localparam int DEF_MAX_WIDTH     = 1024;
    localparam int DEF_SCREEN_WIDTH  = 400;
    localparam int DEF_SCREEN_HEIGHT = 240;
    localparam int DEF_ROW_BYTES     = 50;

    localparam int HEIGHT_LIMIT = 1024;
    localparam int ROW_W        = 10;
    localparam int HEIGHT_W     = 11;
    localparam int CFG_DW       = 11;
    localparam int CFG_IW       = 3;
    localparam int ERR_W        = 9;
    localparam int SHARE_W      = ERR_W + 4;
    localparam int SHARE_SHIFT  = 4;

    localparam int LUM_SUM_W = 18;
    localparam int LUM_DIV   = 1000;
    localparam int LUM_SHIFT = 28;
    localparam int RECIP_W   = 19;
    localparam logic [RECIP_W-1:0] LUM_RECIP =
        RECIP_W'(((1 << LUM_SHIFT) + LUM_DIV - 1) / LUM_DIV);
    localparam logic [9:0] LUM_R = 10'd299;
    localparam logic [9:0] LUM_G = 10'd587;
    localparam logic [9:0] LUM_B = 10'd114;

    localparam logic [7:0] THRESHOLD   = 8'd128;
    localparam logic [7:0] WHITE_LEVEL = 8'd255;

    localparam logic [2:0] SHARE_RIGHT      = 3'd7;
    localparam logic [2:0] SHARE_DOWN_LEFT  = 3'd3;
    localparam logic [2:0] SHARE_DOWN       = 3'd5;
    localparam logic [2:0] SHARE_DOWN_RIGHT = 3'd1;

    localparam logic KIND_PALETTE = 1'b0;
    localparam logic KIND_PIXEL   = 1'b1;

    localparam logic [10:0] RST_ORIGIN_X     = 11'd40;
    localparam logic [10:0] RST_ORIGIN_Y     = 11'd20;
    localparam logic [8:0]  RST_SHAKE_Y      = 9'd0;
    localparam logic [10:0] RST_IMAGE_WIDTH  = 11'd320;
    localparam logic [10:0] RST_IMAGE_HEIGHT = 11'd200;

    typedef enum logic [CFG_IW-1:0] {
        CFG_ORIGIN_X     = 3'd0,
        CFG_ORIGIN_Y     = 3'd1,
        CFG_SHAKE_Y      = 3'd2,
        CFG_IMAGE_WIDTH  = 3'd3,
        CFG_IMAGE_HEIGHT = 3'd4
    } t_cfg_reg;

    typedef struct packed {
        logic       kind;
        logic [7:0] palette_index;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] color_index;
    } t_in_item;

    typedef struct packed {
        logic        pixel_white;
        logic        in_bounds;
        logic [13:0] byte_address;
        logic [2:0]  bit_position;
        logic        last_in_frame;
    } t_out_item;

    // Share of the error, weight/16, with the quotient truncated toward zero.
    function automatic logic signed [ERR_W-1:0] err_share(
        input logic signed [ERR_W-1:0] err,
        input logic [2:0]              weight
    );
        logic signed [SHARE_W-1:0] prod;
        prod = err * $signed({1'b0, weight});
        if (prod < 0) begin
            prod = prod + signed'(SHARE_W'(15));
        end
        return ERR_W'(prod >>> SHARE_SHIFT);
    endfunction

endpackage

// ----- rtl/pfsmd_err_ram.sv -----
// One bank of an error row buffer: one write port and one registered read port.
`timescale 1ns / 1ps

module pfsmd_err_ram import pfsmd_pkg::*; #(
    parameter int DEPTH = 342,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [ERR_W-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [ERR_W-1:0] o_rdata
);

    logic [ERR_W-1:0] r_mem [DEPTH];
    logic [ERR_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/palette_floyd_steinberg_mono_dither.sv -----
// Top level of the palette lookup and Floyd-Steinberg one-bit dither pipeline.
`timescale 1ns / 1ps

// The block takes one input transfer per clock cycle unless the output stalls, palette writes
// and pixels alike, and presents the result of a pixel in the output register: the palette
// read, the weighted color sum and the reciprocal multiply for the luminance are each
// closed by a register, and the error add, threshold and diffusion are closed by the output
// register. The whole pipeline holds while a result waits at the output. Each error row is
// split into three banks by column modulo three, so the three entries a pixel updates go to
// three separate write ports, and the row read for a pixel is forwarded from a write that
// lands in the same cycle. No clearing pass is needed after reset.
module palette_floyd_steinberg_mono_dither import pfsmd_pkg::*; #(
    parameter int MAX_WIDTH     = DEF_MAX_WIDTH,
    parameter int SCREEN_WIDTH  = DEF_SCREEN_WIDTH,
    parameter int SCREEN_HEIGHT = DEF_SCREEN_HEIGHT,
    parameter int ROW_BYTES     = DEF_ROW_BYTES
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  t_in_item          i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output t_out_item         o_out_data,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [CFG_IW-1:0] i_cfg_index,
    input  logic [CFG_DW-1:0] i_cfg_data
);

    localparam int CW         = $clog2(MAX_WIDTH);
    localparam int WW         = (CW + 1 > CFG_DW) ? CW + 1 : CFG_DW;
    localparam int SXW        = WW + 1;
    localparam int SYW        = 13;
    localparam int PW         = SYW + 9;
    localparam int BANK_DEPTH = (MAX_WIDTH + 4) / 3;
    localparam int AW         = $clog2(BANK_DEPTH);

    typedef struct packed {
        logic          col_zero;
        logic          row_zero;
        logic          sel;
        logic [1:0]    m;
        logic [AW-1:0] q;
        logic          last;
    } t_pix_meta;

    // Configuration registers.
    logic [10:0] r_cfg_ox;
    logic [10:0] r_cfg_oy;
    logic [8:0]  r_cfg_shake;
    logic [10:0] r_cfg_width;
    logic [10:0] r_cfg_height;
    logic        cfg_we;

    assign o_cfg_ready = 1'b1;
    assign cfg_we      = i_cfg_valid && o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_ox     <= RST_ORIGIN_X;
            r_cfg_oy     <= RST_ORIGIN_Y;
            r_cfg_shake  <= RST_SHAKE_Y;
            r_cfg_width  <= RST_IMAGE_WIDTH;
            r_cfg_height <= RST_IMAGE_HEIGHT;
        end else if (cfg_we) begin
            unique case (t_cfg_reg'(i_cfg_index))
                CFG_ORIGIN_X:     r_cfg_ox     <= i_cfg_data;
                CFG_ORIGIN_Y:     r_cfg_oy     <= i_cfg_data;
                CFG_SHAKE_Y:      r_cfg_shake  <= i_cfg_data[8:0];
                CFG_IMAGE_WIDTH:  r_cfg_width  <= i_cfg_data;
                CFG_IMAGE_HEIGHT: r_cfg_height <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Handshake and pipeline advance.
    logic en;
    logic in_acc;
    logic pix_acc;
    logic pal_we;
    logic r_out_vld;

    assign en         = !r_out_vld || i_out_ready;
    assign o_in_ready = en;
    assign in_acc     = i_in_valid && en;
    assign pix_acc    = in_acc && (i_in_data.kind == KIND_PIXEL);
    assign pal_we     = in_acc && (i_in_data.kind == KIND_PALETTE);

    // Raster counters.
    logic [CW-1:0]       r_col;
    logic [ROW_W-1:0]    r_row;
    logic                r_sel;
    logic [1:0]          r_m;
    logic [AW-1:0]       r_q;
    logic [WW-1:0]       w_eff;
    logic [HEIGHT_W-1:0] h_eff;
    logic [WW-1:0]       n_col_inc;
    logic [HEIGHT_W-1:0] n_row_inc;
    logic                row_end;
    logic                frame_end;
    t_pix_meta           n_meta;
    logic [SXW-1:0]      n_sx;
    logic [SYW-1:0]      n_sy;

    always_comb begin
        if (r_cfg_width == '0) begin
            w_eff = WW'(1);
        end else if (WW'(r_cfg_width) > WW'(MAX_WIDTH)) begin
            w_eff = WW'(MAX_WIDTH);
        end else begin
            w_eff = WW'(r_cfg_width);
        end
        if (r_cfg_height == '0) begin
            h_eff = HEIGHT_W'(1);
        end else if (r_cfg_height > HEIGHT_W'(HEIGHT_LIMIT)) begin
            h_eff = HEIGHT_W'(HEIGHT_LIMIT);
        end else begin
            h_eff = r_cfg_height;
        end
        n_col_inc = WW'(r_col) + WW'(1);
        n_row_inc = HEIGHT_W'(r_row) + HEIGHT_W'(1);
        row_end   = n_col_inc >= w_eff;
        frame_end = row_end && (n_row_inc >= h_eff);

        n_meta.col_zero = (r_col == '0);
        n_meta.row_zero = (r_row == '0);
        n_meta.sel      = r_sel;
        n_meta.m        = r_m;
        n_meta.q        = r_q;
        n_meta.last     = frame_end;

        n_sx = {{(SXW - 11){r_cfg_ox[10]}}, r_cfg_ox} + SXW'(r_col);
        n_sy = {{(SYW - 11){r_cfg_oy[10]}}, r_cfg_oy} + SYW'(r_row)
             + {{(SYW - 9){r_cfg_shake[8]}}, r_cfg_shake};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
            r_sel <= 1'b0;
            r_m   <= 2'd0;
            r_q   <= '0;
        end else if (pix_acc) begin
            if (row_end) begin
                r_col <= '0;
                r_m   <= 2'd0;
                r_q   <= '0;
                r_sel <= ~r_sel;
                r_row <= frame_end ? '0 : ROW_W'(n_row_inc);
            end else begin
                r_col <= CW'(n_col_inc);
                r_m   <= (r_m == 2'd2) ? 2'd0 : r_m + 2'd1;
                r_q   <= (r_m == 2'd2) ? r_q + AW'(1) : r_q;
            end
        end
    end

    // Palette memory; an entry never written reads as zero.
    logic [23:0]  r_pal_mem [256];
    logic [255:0] r_pal_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pal_vld <= '0;
        end else if (pal_we) begin
            r_pal_vld[i_in_data.palette_index] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pal_we) begin
            r_pal_mem[i_in_data.palette_index] <=
                {i_in_data.red, i_in_data.green, i_in_data.blue};
        end
    end

    // Pipeline valid bits.
    logic r_s1_vld;
    logic r_s2_vld;
    logic r_s3_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_s2_vld  <= 1'b0;
            r_s3_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_s1_vld  <= pix_acc;
            r_s2_vld  <= r_s1_vld;
            r_s3_vld  <= r_s2_vld;
            r_out_vld <= r_s3_vld;
        end
    end

    // Stage 1: palette data, weighted color sum, screen position.
    logic [23:0]          r_s1_rgb;
    logic                 r_s1_pal_ok;
    t_pix_meta            r_s1_meta;
    logic [SXW-1:0]       r_s1_sx;
    logic [SYW-1:0]       r_s1_sy;
    logic [23:0]          s1_rgb;
    logic [LUM_SUM_W-1:0] n_s2_sum;
    logic                 n_s2_inb;
    logic [PW-1:0]        s1_prod;
    logic [13:0]          n_s2_addr;
    logic [2:0]           n_s2_bit;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1_rgb    <= r_pal_mem[i_in_data.color_index];
            r_s1_pal_ok <= r_pal_vld[i_in_data.color_index];
            r_s1_meta   <= n_meta;
            r_s1_sx     <= n_sx;
            r_s1_sy     <= n_sy;
        end
    end

    always_comb begin
        s1_rgb   = r_s1_pal_ok ? r_s1_rgb : '0;
        n_s2_sum = LUM_SUM_W'(s1_rgb[23:16]) * LUM_SUM_W'(LUM_R)
                 + LUM_SUM_W'(s1_rgb[15:8]) * LUM_SUM_W'(LUM_G)
                 + LUM_SUM_W'(s1_rgb[7:0]) * LUM_SUM_W'(LUM_B);
        n_s2_inb = !r_s1_sx[SXW-1] && (r_s1_sx < SXW'(SCREEN_WIDTH))
                 && !r_s1_sy[SYW-1] && (r_s1_sy < SYW'(SCREEN_HEIGHT));
        s1_prod  = PW'(r_s1_sy) * PW'(ROW_BYTES);
        if (n_s2_inb) begin
            n_s2_addr = 14'(s1_prod + PW'(r_s1_sx[SXW-1:3]));
            n_s2_bit  = ~r_s1_sx[2:0];
        end else begin
            n_s2_addr = '0;
            n_s2_bit  = '0;
        end
    end

    // Stage 2: luminance by reciprocal multiply, error row read.
    logic [LUM_SUM_W-1:0]         r_s2_sum;
    t_pix_meta                    r_s2_meta;
    logic                         r_s2_inb;
    logic [13:0]                  r_s2_addr;
    logic [2:0]                   r_s2_bit;
    logic [LUM_SUM_W+RECIP_W-1:0] s2_prod;
    logic [7:0]                   n_s3_lum;
    logic [1:0]                   rd_bank;
    logic [AW-1:0]                rd_addr;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s2_sum  <= n_s2_sum;
            r_s2_meta <= r_s1_meta;
            r_s2_inb  <= n_s2_inb;
            r_s2_addr <= n_s2_addr;
            r_s2_bit  <= n_s2_bit;
        end
    end

    always_comb begin
        s2_prod  = (LUM_SUM_W + RECIP_W)'(r_s2_sum) * (LUM_SUM_W + RECIP_W)'(LUM_RECIP);
        n_s3_lum = s2_prod[LUM_SHIFT +: 8];
        rd_bank  = (r_s2_meta.m == 2'd2) ? 2'd0 : r_s2_meta.m + 2'd1;
        rd_addr  = (r_s2_meta.m == 2'd2) ? r_s2_meta.q + AW'(1) : r_s2_meta.q;
    end

    // Stage 3: error add, threshold and diffusion.
    logic [7:0]              r_s3_lum;
    t_pix_meta               r_s3_meta;
    logic                    r_s3_inb;
    logic [13:0]             r_s3_addr;
    logic [2:0]              r_s3_bit;
    logic                    r_s3_fwd_hit;
    logic [ERR_W-1:0]        r_s3_fwd_data;
    logic signed [ERR_W-1:0] r_carry;
    logic signed [ERR_W-1:0] r_w1;
    logic signed [ERR_W-1:0] r_w2;
    logic [ERR_W-1:0]        ram_q [2][3];
    logic [1:0]              s3_rb;
    logic [1:0]              s3_m_p1;
    logic signed [ERR_W-1:0] s3_base;
    logic signed [ERR_W-1:0] s3_carry;
    logic signed [10:0]      s3_sum;
    logic [7:0]              s3_clip;
    logic                    s3_white;
    logic signed [ERR_W-1:0] s3_err;
    logic signed [ERR_W-1:0] e7;
    logic signed [ERR_W-1:0] e3;
    logic signed [ERR_W-1:0] e5;
    logic signed [ERR_W-1:0] e1;
    logic signed [ERR_W-1:0] v0;
    logic signed [ERR_W-1:0] v1;
    logic signed [ERR_W-1:0] v2;
    logic [AW-1:0]           wr_addr [3];
    logic [ERR_W-1:0]        wr_data [3];
    logic                    n_fwd_hit;
    logic [ERR_W-1:0]        n_fwd_data;

    always_comb begin
        s3_rb   = (r_s3_meta.m == 2'd2) ? 2'd0 : r_s3_meta.m + 2'd1;
        s3_m_p1 = s3_rb;
        if (r_s3_meta.row_zero) begin
            s3_base = '0;
        end else if (r_s3_fwd_hit) begin
            s3_base = r_s3_fwd_data;
        end else begin
            s3_base = ram_q[r_s3_meta.sel][s3_rb];
        end
        s3_carry = r_s3_meta.col_zero ? '0 : r_carry;
        s3_sum   = $signed({3'b000, r_s3_lum})
                 + $signed({{2{s3_base[ERR_W-1]}}, s3_base})
                 + $signed({{2{s3_carry[ERR_W-1]}}, s3_carry});
        if (s3_sum < 0) begin
            s3_clip = 8'd0;
        end else if (s3_sum > 11'sd255) begin
            s3_clip = WHITE_LEVEL;
        end else begin
            s3_clip = s3_sum[7:0];
        end
        s3_white = s3_clip >= THRESHOLD;
        s3_err   = s3_white ? ERR_W'({1'b0, s3_clip} - {1'b0, WHITE_LEVEL})
                            : ERR_W'({1'b0, s3_clip});
        e7 = err_share(s3_err, SHARE_RIGHT);
        e3 = err_share(s3_err, SHARE_DOWN_LEFT);
        e5 = err_share(s3_err, SHARE_DOWN);
        e1 = err_share(s3_err, SHARE_DOWN_RIGHT);
        v0 = r_s3_meta.col_zero ? e3 : r_w1 + e3;
        v1 = r_s3_meta.col_zero ? e5 : r_w2 + e5;
        v2 = e1;
        for (int b = 0; b < 3; b++) begin
            if (2'(b) == r_s3_meta.m) begin
                wr_addr[b] = r_s3_meta.q;
                wr_data[b] = v0;
            end else if (2'(b) == s3_m_p1) begin
                wr_addr[b] = (r_s3_meta.m == 2'd2) ? r_s3_meta.q + AW'(1) : r_s3_meta.q;
                wr_data[b] = v1;
            end else begin
                wr_addr[b] = (r_s3_meta.m != 2'd0) ? r_s3_meta.q + AW'(1) : r_s3_meta.q;
                wr_data[b] = v2;
            end
        end
        n_fwd_hit  = r_s3_vld && (r_s3_meta.sel != r_s2_meta.sel)
                   && (wr_addr[rd_bank] == rd_addr);
        n_fwd_data = wr_data[rd_bank];
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s3_lum      <= n_s3_lum;
            r_s3_meta     <= r_s2_meta;
            r_s3_inb      <= r_s2_inb;
            r_s3_addr     <= r_s2_addr;
            r_s3_bit      <= r_s2_bit;
            r_s3_fwd_hit  <= n_fwd_hit;
            r_s3_fwd_data <= n_fwd_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_carry <= '0;
            r_w1    <= '0;
            r_w2    <= '0;
        end else if (en && r_s3_vld) begin
            r_carry <= e7;
            r_w1    <= v1;
            r_w2    <= v2;
        end
    end

    for (genvar g_buf = 0; g_buf < 2; g_buf++) begin : g_row
        for (genvar g_bank = 0; g_bank < 3; g_bank++) begin : g_bank_ram
            pfsmd_err_ram #(
                .DEPTH (BANK_DEPTH)
            ) u_ram (
                .i_clk   (i_clk),
                .i_we    (en && r_s3_vld && (r_s3_meta.sel != 1'(g_buf))),
                .i_waddr (wr_addr[g_bank]),
                .i_wdata (wr_data[g_bank]),
                .i_re    (en),
                .i_raddr (rd_addr),
                .o_rdata (ram_q[g_buf][g_bank])
            );
        end
    end

    // Output register.
    t_out_item r_out;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out.pixel_white   <= s3_white;
            r_out.in_bounds     <= r_s3_inb;
            r_out.byte_address  <= r_s3_addr;
            r_out.bit_position  <= r_s3_bit;
            r_out.last_in_frame <= r_s3_meta.last;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

`ifndef SYNTHESIS
    a_col_split: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (32'(r_q) * 3 + 32'(r_m)) == 32'(r_col))
        else $error("column bank split out of step with the column counter");

    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_col) < MAX_WIDTH)
        else $error("column counter beyond the row buffer");

    a_pal_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pal_we |=> !r_s1_vld)
        else $error("palette write entered the pixel pipeline");

    a_pix_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (en && r_s3_vld) |=> o_out_valid)
        else $error("pixel lost between the last stage and the output register");
`endif

endmodule
